[rtl/core/bilinear_grid_sampler_unit_defines.svh]
// ----------------------------------------------------------------------------
// Bilinear grid sampler assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BILINEAR_GRID_SAMPLER_UNIT_DEFINES_SVH
`define BILINEAR_GRID_SAMPLER_UNIT_DEFINES_SVH

// condition must hold at every edge out of reset
`define BGS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// antecedent at one edge implies the consequent sequence from that edge
`define BGS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[rtl/core/bgs_pkg.sv]
// ----------------------------------------------------------------------------
// Bilinear grid sampler package
// Shared constants, register codes and inter-module control types.
// ----------------------------------------------------------------------------
package bgs_pkg;

    localparam int DEF_MAX_WIDTH       = 64;
    localparam int DEF_MAX_HEIGHT      = 64;
    localparam int DEF_PIXEL_BITS      = 16;
    localparam int DEF_COORD_FRAC_BITS = 14;

    localparam int COORD_BITS     = 16;
    localparam int LOAD_BITS      = 6;
    localparam int DIM_REG_BITS   = 7;
    localparam int CFG_INDEX_BITS = 2;
    localparam int DIM_RESET      = 64;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1
    } cfg_reg_e;

    // corner flags of one axis: lower neighbor / upper neighbor inside plane
    typedef struct packed {
        logic hi;
        logic lo;
    } axis_in_t;

    // corner inside flags, named row then column offset
    typedef struct packed {
        logic c11;
        logic c10;
        logic c01;
        logic c00;
    } corner_ok_t;

    // width of (g + one) for the coordinate add
    function automatic int axis_sum_w(int frac_bits);
        int w;
        w = (COORD_BITS > frac_bits + 1) ? COORD_BITS : frac_bits + 1;
        return w + 1;
    endfunction

    // width of the integer pixel index out of the axis mapper
    function automatic int axis_base_w(int dim_w, int frac_bits);
        return axis_sum_w(frac_bits) + dim_w + 1 - frac_bits - 1;
    endfunction

endpackage

[rtl/core/bgs_axis_map.sv]
// ----------------------------------------------------------------------------
// Bilinear grid sampler axis mapper
// Maps a normalized coordinate onto pixel index and fraction over two stages.
// ----------------------------------------------------------------------------
module bgs_axis_map #(
    parameter int MAX_DIM   = bgs_pkg::DEF_MAX_WIDTH,
    parameter int FRAC_BITS = bgs_pkg::DEF_COORD_FRAC_BITS,
    parameter int DIM_W     = $clog2(MAX_DIM + 1),
    parameter int BASE_W    = bgs_pkg::axis_base_w(DIM_W, FRAC_BITS)
)(
    input  logic                                 clk,
    input  logic signed [bgs_pkg::COORD_BITS-1:0] coord,
    input  logic        [DIM_W-1:0]              size,
    output logic signed [BASE_W-1:0]             base,
    output logic        [FRAC_BITS-1:0]          frac,
    output bgs_pkg::axis_in_t                    in_plane
);
    import bgs_pkg::*;

    localparam int SUM_W  = axis_sum_w(FRAC_BITS);
    localparam int PROD_W = SUM_W + DIM_W + 1;
    localparam int CMP_W  = ((BASE_W > DIM_W) ? BASE_W : DIM_W) + 2;
    localparam logic signed [SUM_W-1:0] ONE = SUM_W'(1) << FRAC_BITS;

    logic signed [SUM_W-1:0]   shifted;
    logic signed [DIM_W:0]     span;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [BASE_W-1:0]  base_reg, base_next;
    logic        [FRAC_BITS-1:0] frac_reg, frac_next;
    axis_in_t                  in_plane_reg, in_plane_next;
    logic signed [CMP_W-1:0]   lo_pos, hi_pos, size_cmp;

    // stage 1: (g + one) * (size - 1)
    always_comb
    begin
        shifted   = SUM_W'(coord) + ONE;
        span      = signed'({1'b0, size - 1'b1});
        prod_next = PROD_W'(shifted) * PROD_W'(span);
    end

    // stage 2: halving is folded into the bit selects
    always_comb
    begin
        base_next        = prod_reg[PROD_W-1:FRAC_BITS+1];
        frac_next        = prod_reg[FRAC_BITS:1];
        lo_pos           = CMP_W'(base_next);
        hi_pos           = lo_pos + signed'(CMP_W'(1));
        size_cmp         = CMP_W'(signed'({1'b0, size}));
        in_plane_next.lo = !lo_pos[CMP_W-1] && (lo_pos < size_cmp);
        in_plane_next.hi = !hi_pos[CMP_W-1] && (hi_pos < size_cmp);
    end

    always_ff @(posedge clk)
    begin
        prod_reg     <= prod_next;
        base_reg     <= base_next;
        frac_reg     <= frac_next;
        in_plane_reg <= in_plane_next;
    end

    assign base     = base_reg;
    assign frac     = frac_reg;
    assign in_plane = in_plane_reg;

endmodule

[rtl/core/bgs_store.sv]
// ----------------------------------------------------------------------------
// Bilinear grid sampler image store
// Four banks split by row and column parity; one write and four reads a cycle.
// ----------------------------------------------------------------------------
module bgs_store #(
    parameter int MAX_WIDTH  = bgs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bgs_pkg::DEF_MAX_HEIGHT,
    parameter int PIXEL_BITS = bgs_pkg::DEF_PIXEL_BITS,
    parameter int XB         = 16,
    parameter int YB         = 16
)(
    input  logic                                clk,
    input  logic                                wr_en,
    input  logic        [bgs_pkg::LOAD_BITS-1:0] wr_row,
    input  logic        [bgs_pkg::LOAD_BITS-1:0] wr_col,
    input  logic signed [PIXEL_BITS-1:0]        wr_data,
    input  logic signed [XB-1:0]                base_x,
    input  logic signed [YB-1:0]                base_y,
    output logic signed [PIXEL_BITS-1:0]        corner_pix [4]
);
    import bgs_pkg::*;

    localparam int RB         = ($clog2(MAX_HEIGHT) < 2) ? 2 : $clog2(MAX_HEIGHT);
    localparam int CB         = ($clog2(MAX_WIDTH) < 2) ? 2 : $clog2(MAX_WIDTH);
    localparam int AW         = RB + CB - 2;
    localparam int BANK_DEPTH = 1 << AW;

    logic [31:0]            wr_row_w, wr_col_w;
    logic                   wr_ok;
    logic [1:0]             wr_bank;
    logic [AW-1:0]          wr_addr;
    logic signed [31:0]     x0, x1, y0, y1;
    logic [AW-1:0]          rd_addr [4];
    logic [PIXEL_BITS-1:0]  rd_reg [4];
    logic                   par_x_reg, par_y_reg;

    always_comb
    begin
        wr_row_w = 32'(wr_row);
        wr_col_w = 32'(wr_col);
        wr_ok    = wr_en && (wr_row_w < 32'(MAX_HEIGHT)) && (wr_col_w < 32'(MAX_WIDTH));
        wr_bank  = {wr_row_w[0], wr_col_w[0]};
        wr_addr  = {wr_row_w[RB-1:1], wr_col_w[CB-1:1]};
    end

    // even bank of an axis holds index (b+1)>>1, odd bank holds b>>1
    always_comb
    begin
        x0 = 32'(base_x);
        y0 = 32'(base_y);
        x1 = x0 + 32'sd1;
        y1 = y0 + 32'sd1;
        for (int b = 0; b < 4; b++)
        begin
            rd_addr[b] = {(b[1] ? y0[RB-1:1] : y1[RB-1:1]),
                          (b[0] ? x0[CB-1:1] : x1[CB-1:1])};
        end
    end

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        logic [PIXEL_BITS-1:0] mem [BANK_DEPTH];

        always_ff @(posedge clk)
        begin
            if (wr_ok && (wr_bank == 2'(b)))
            begin
                mem[wr_addr] <= wr_data;
            end
            rd_reg[b] <= mem[rd_addr[b]];
        end
    end

    always_ff @(posedge clk)
    begin
        par_x_reg <= x0[0];
        par_y_reg <= y0[0];
    end

    // corner {dy,dx} sits in bank {row parity, column parity}
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            corner_pix[c] = signed'(rd_reg[{par_y_reg ^ c[1], par_x_reg ^ c[0]}]);
        end
    end

endmodule

[rtl/core/bgs_blend.sv]
// ----------------------------------------------------------------------------
// Bilinear grid sampler blend
// Corner weights, weighted pixels, then sum, rounding and saturation.
// ----------------------------------------------------------------------------
module bgs_blend #(
    parameter int PIXEL_BITS = bgs_pkg::DEF_PIXEL_BITS,
    parameter int FRAC_BITS  = bgs_pkg::DEF_COORD_FRAC_BITS
)(
    input  logic                         clk,
    input  logic [FRAC_BITS-1:0]         frac_x,
    input  logic [FRAC_BITS-1:0]         frac_y,
    input  bgs_pkg::corner_ok_t          ok,
    input  logic signed [PIXEL_BITS-1:0] corner_pix [4],
    input  logic                         out_en,
    output logic signed [PIXEL_BITS-1:0] sample_value
);
    import bgs_pkg::*;

    localparam int WT_W   = FRAC_BITS + 1;
    localparam int MUL_W  = 2 * WT_W;
    localparam int PROD_W = PIXEL_BITS + WT_W + 1;
    localparam int SUM_W  = PROD_W + 2;
    localparam int RES_W  = SUM_W - FRAC_BITS;
    localparam logic [WT_W-1:0]  ONE  = WT_W'(1) << FRAC_BITS;
    localparam logic [MUL_W-1:0] HALF = MUL_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [SUM_W-1:0] RND = SUM_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [RES_W-1:0] HI =
        RES_W'((64'(1) << (PIXEL_BITS - 1)) - 64'(1));
    localparam logic signed [RES_W-1:0] LO = ~HI;

    logic [WT_W-1:0]            wx [2];
    logic [WT_W-1:0]            wy [2];
    logic [MUL_W-1:0]           wmul [4];
    logic [3:0]                 ok_bits;
    logic [WT_W-1:0]            wt_reg [4], wt_next [4];
    logic signed [PROD_W-1:0]   prod_reg [4], prod_next [4];
    logic signed [SUM_W-1:0]    sum, rounded;
    logic signed [RES_W-1:0]    res;
    logic signed [PIXEL_BITS-1:0] sample_reg, sample_next;

    // stage 3 weights: outside corners get weight zero
    always_comb
    begin
        wx[0]   = ONE - WT_W'(frac_x);
        wx[1]   = WT_W'(frac_x);
        wy[0]   = ONE - WT_W'(frac_y);
        wy[1]   = WT_W'(frac_y);
        ok_bits = {ok.c11, ok.c10, ok.c01, ok.c00};
        for (int c = 0; c < 4; c++)
        begin
            wmul[c]    = MUL_W'(wx[c[0]]) * MUL_W'(wy[c[1]]) + HALF;
            wt_next[c] = ok_bits[c] ? wmul[c][FRAC_BITS+WT_W-1:FRAC_BITS] : '0;
        end
    end

    // stage 4 weighted pixels; a zero weight skips the word, which for a
    // corner off the plane may never have been loaded
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            prod_next[c] = (wt_reg[c] == '0) ? '0
                         : PROD_W'(corner_pix[c]) * PROD_W'(signed'({1'b0, wt_reg[c]}));
        end
    end

    // output stage: sum, round half up, saturate
    always_comb
    begin
        sum = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1])
            + SUM_W'(prod_reg[2]) + SUM_W'(prod_reg[3]);
        rounded = sum + RND;
        res     = RES_W'(rounded >>> FRAC_BITS);
        if (res > HI)
        begin
            sample_next = HI[PIXEL_BITS-1:0];
        end
        else if (res < LO)
        begin
            sample_next = LO[PIXEL_BITS-1:0];
        end
        else
        begin
            sample_next = res[PIXEL_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        wt_reg   <= wt_next;
        prod_reg <= prod_next;
        if (out_en)
        begin
            sample_reg <= sample_next;
        end
    end

    assign sample_value = sample_reg;

endmodule

[rtl/core/bilinear_grid_sampler_unit.sv]
// ----------------------------------------------------------------------------
// Bilinear grid sampler unit
// Pixel loads into a banked plane store and zero-padded bilinear samples.
// ----------------------------------------------------------------------------
// Channel   Handshake         Payload
// request   start / busy      req_type, load_row, load_col, pixel_value,
//                             grid_x, grid_y
// result    done (strobe)     sample_value
// config    cfg_we            cfg_index, cfg_data
//
// One request per cycle; busy stays low. A sample leaves on done after these
// registered steps in order: mapping multiply, index/fraction, store read with
// weights, weighted products, sum and round. The four corner reads come from
// four parity banks in the same cycle. Loads write the store in request order.
// Reset clears valid bits and sets both dimensions; the store is not cleared.
// The receiver cannot stall done, so the pipeline never backs up.
// ----------------------------------------------------------------------------
`include "bilinear_grid_sampler_unit_defines.svh"

module bilinear_grid_sampler_unit #(
    parameter int MAX_WIDTH       = bgs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT      = bgs_pkg::DEF_MAX_HEIGHT,
    parameter int PIXEL_BITS      = bgs_pkg::DEF_PIXEL_BITS,
    parameter int COORD_FRAC_BITS = bgs_pkg::DEF_COORD_FRAC_BITS
)(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     start,
    output logic                                     busy,
    input  logic                                     req_type,
    input  logic        [bgs_pkg::LOAD_BITS-1:0]      load_row,
    input  logic        [bgs_pkg::LOAD_BITS-1:0]      load_col,
    input  logic signed [PIXEL_BITS-1:0]             pixel_value,
    input  logic signed [bgs_pkg::COORD_BITS-1:0]     grid_x,
    input  logic signed [bgs_pkg::COORD_BITS-1:0]     grid_y,
    output logic                                     done,
    output logic signed [PIXEL_BITS-1:0]             sample_value,
    input  logic                                     cfg_we,
    input  logic        [bgs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic        [bgs_pkg::DIM_REG_BITS-1:0]   cfg_data
);
    import bgs_pkg::*;

    localparam int W_DW  = $clog2(MAX_WIDTH + 1);
    localparam int H_DW  = $clog2(MAX_HEIGHT + 1);
    localparam int X_BW  = axis_base_w(W_DW, COORD_FRAC_BITS);
    localparam int Y_BW  = axis_base_w(H_DW, COORD_FRAC_BITS);
    localparam int RST_W = (DIM_RESET > MAX_WIDTH) ? MAX_WIDTH : DIM_RESET;
    localparam int RST_H = (DIM_RESET > MAX_HEIGHT) ? MAX_HEIGHT : DIM_RESET;

    logic                         accept;
    logic [W_DW-1:0]              width_reg, width_next;
    logic [H_DW-1:0]              height_reg, height_next;

    logic                         s1_valid_reg, s1_sample_reg;
    logic                         s2_valid_reg, s2_sample_reg;
    logic                         s3_valid_reg, s4_valid_reg, done_reg;
    logic [LOAD_BITS-1:0]         s1_row_reg, s1_col_reg, s2_row_reg, s2_col_reg;
    logic signed [PIXEL_BITS-1:0] s1_pix_reg, s2_pix_reg;

    logic signed [X_BW-1:0]       base_x;
    logic signed [Y_BW-1:0]       base_y;
    logic [COORD_FRAC_BITS-1:0]   frac_x, frac_y;
    axis_in_t                     in_x, in_y;
    corner_ok_t                   corner_ok;
    logic signed [PIXEL_BITS-1:0] corner_pix [4];

    // zero acts as one, anything past the store acts as the store size
    function automatic int clamp_dim(logic [DIM_REG_BITS-1:0] v, int max_v);
        int r;
        r = int'(v);
        if (r == 0)
        begin
            r = 1;
        end
        else if (r > max_v)
        begin
            r = max_v;
        end
        return r;
    endfunction

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we)
        begin
            unique case (cfg_reg_e'(cfg_index))
                REG_IMAGE_WIDTH:  width_next  = W_DW'(clamp_dim(cfg_data, MAX_WIDTH));
                REG_IMAGE_HEIGHT: height_next = H_DW'(clamp_dim(cfg_data, MAX_HEIGHT));
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= W_DW'(RST_W);
            height_reg    <= H_DW'(RST_H);
            s1_valid_reg  <= 1'b0;
            s1_sample_reg <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s2_sample_reg <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            width_reg     <= width_next;
            height_reg    <= height_next;
            s1_valid_reg  <= accept;
            s1_sample_reg <= (req_type == REQ_SAMPLE);
            s2_valid_reg  <= s1_valid_reg;
            s2_sample_reg <= s1_sample_reg;
            s3_valid_reg  <= s2_valid_reg && s2_sample_reg;
            s4_valid_reg  <= s3_valid_reg;
            done_reg      <= s4_valid_reg;
        end
    end

    // load payload rides along so the write lands in request order
    always_ff @(posedge clk)
    begin
        s1_row_reg <= load_row;
        s1_col_reg <= load_col;
        s1_pix_reg <= pixel_value;
        s2_row_reg <= s1_row_reg;
        s2_col_reg <= s1_col_reg;
        s2_pix_reg <= s1_pix_reg;
    end

    bgs_axis_map #(
        .MAX_DIM   (MAX_WIDTH),
        .FRAC_BITS (COORD_FRAC_BITS)
    ) u_map_x (
        .clk      (clk),
        .coord    (grid_x),
        .size     (width_reg),
        .base     (base_x),
        .frac     (frac_x),
        .in_plane (in_x)
    );

    bgs_axis_map #(
        .MAX_DIM   (MAX_HEIGHT),
        .FRAC_BITS (COORD_FRAC_BITS)
    ) u_map_y (
        .clk      (clk),
        .coord    (grid_y),
        .size     (height_reg),
        .base     (base_y),
        .frac     (frac_y),
        .in_plane (in_y)
    );

    always_comb
    begin
        corner_ok.c00 = in_y.lo && in_x.lo;
        corner_ok.c01 = in_y.lo && in_x.hi;
        corner_ok.c10 = in_y.hi && in_x.lo;
        corner_ok.c11 = in_y.hi && in_x.hi;
    end

    bgs_store #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .PIXEL_BITS (PIXEL_BITS),
        .XB         (X_BW),
        .YB         (Y_BW)
    ) u_store (
        .clk        (clk),
        .wr_en      (s2_valid_reg && !s2_sample_reg),
        .wr_row     (s2_row_reg),
        .wr_col     (s2_col_reg),
        .wr_data    (s2_pix_reg),
        .base_x     (base_x),
        .base_y     (base_y),
        .corner_pix (corner_pix)
    );

    bgs_blend #(
        .PIXEL_BITS (PIXEL_BITS),
        .FRAC_BITS  (COORD_FRAC_BITS)
    ) u_blend (
        .clk          (clk),
        .frac_x       (frac_x),
        .frac_y       (frac_y),
        .ok           (corner_ok),
        .corner_pix   (corner_pix),
        .out_en       (s4_valid_reg),
        .sample_value (sample_value)
    );

    assign done = done_reg;

    `BGS_ASSERT_IMPLY(a_sample_done, start && !busy && req_type == REQ_SAMPLE, ##5 done, "sample request without result")
    `BGS_ASSERT_IMPLY(a_load_quiet, start && !busy && req_type == REQ_LOAD, ##5 !done, "load request produced a result")
    `BGS_ASSERT_ALWAYS(a_dim_range, width_reg != '0 && 32'(width_reg) <= MAX_WIDTH && height_reg != '0 && 32'(height_reg) <= MAX_HEIGHT, "plane size out of range")

endmodule
